/* hw/rtl/swlf_pkg.sv */
package swlf_pkg;

   // window geometry (WINDOW must be a power of two: divides by WINDOW are shifts)
   localparam int WINDOW = 16;
   localparam int IDX_W  = $clog2(WINDOW);
   localparam int CNT_W  = IDX_W + 1;

   // field widths
   localparam int DT_W   = 16;
   localparam int SMP_W  = 16;
   localparam int TIME_W = 20;
   localparam int OUT_W  = 48;
   localparam int MAR_W  = 47;
   localparam int FRAC_W = 16;

   // shared multiplier
   localparam int MUL_W  = 26;
   localparam int PROD_W = 2 * MUL_W;

   // running sums
   localparam int T0_W = 2 * TIME_W + IDX_W;
   localparam int T1_W = TIME_W + IDX_W;
   localparam int T2_W = TIME_W + SMP_W + IDX_W + 1;
   localparam int T3_W = SMP_W + IDX_W;

   // split points for the wide products
   localparam int T0_LO_W = 22;
   localparam int T2_LO_W = 21;
   localparam int K_LO_W  = 24;

   // fit terms
   localparam int DEN_W  = T0_W + IDX_W + 1;
   localparam int NK_W   = 48;
   localparam int NB_W   = 66;
   localparam int DIVN_W = NB_W + FRAC_W;
   localparam int DIVC_W = $clog2(DIVN_W);
   localparam int R_W    = 70;
   localparam int ACC_W  = R_W + IDX_W;

   // sequencer
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_ACC  = 7'b0000010,
      ST_PREP = 7'b0000100,
      ST_DIVK = 7'b0001000,
      ST_DIVB = 7'b0010000,
      ST_RES  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   // divider handshake
   typedef struct packed {
      logic              start;
      logic [DIVN_W-1:0] dividend;
      logic [DEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVN_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* hw/rtl/swlf_req_if.sv */
interface swlf_req_if import swlf_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic        [DT_W-1:0]  delta_time;
   logic signed [SMP_W-1:0] sample;

   modport source (output valid, output delta_time, output sample, input ready);
   modport sink   (input valid, input delta_time, input sample, output ready);
endinterface

/* hw/rtl/swlf_rsp_if.sv */
interface swlf_rsp_if import swlf_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] slope;
   logic signed [OUT_W-1:0] intercept;
   logic signed [OUT_W-1:0] smoothed;
   logic        [MAR_W-1:0] mean_abs_residual;
   logic                    fit_valid;

   modport source (output valid, output slope, output intercept, output smoothed,
                   output mean_abs_residual, output fit_valid, input ready);
   modport sink   (input valid, input slope, input intercept, input smoothed,
                   input mean_abs_residual, input fit_valid, output ready);
endinterface

/* hw/rtl/sliding_window_line_fit.sv */
// Least-squares line fit over a sliding window of the 16 newest (time, sample)
// pairs. Each accepted item shifts the window, re-bases the times so the oldest
// is zero, appends the new pair, then fits y = k*x + b (Q31.16 results, plus
// the fitted value at the newest time and the mean absolute residual). One
// item is processed at a time, paced by one shared 26x26 multiplier that
// walks the window twice and by a bit-serial divider that runs 82 steps for
// the slope and again for the intercept; both divides and the second walk
// are skipped when the denominator is not positive. req ready is high
// only while the block is idle; a finished result waits in the output
// register, so the next item can be taken before it is collected.
module sliding_window_line_fit import swlf_pkg::*; (
   input logic        clock,
   input logic        reset,
   swlf_req_if.sink   req_chan,
   swlf_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;
   logic [3:0]       sub_ff, sub_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   logic        [TIME_W-1:0] time_ff [WINDOW];
   logic        [TIME_W-1:0] time_in [WINDOW];
   logic signed [SMP_W-1:0]  smp_ff  [WINDOW];
   logic signed [SMP_W-1:0]  smp_in  [WINDOW];

   logic        [T0_W-1:0]  t0_ff,  t0_in;
   logic        [T1_W-1:0]  t1_ff,  t1_in;
   logic signed [T2_W-1:0]  t2_ff,  t2_in;
   logic signed [T3_W-1:0]  t3_ff,  t3_in;
   logic signed [DEN_W-1:0] den_ff, den_in;
   logic signed [NK_W-1:0]  nk_ff,  nk_in;
   logic signed [NB_W-1:0]  nb_ff,  nb_in;
   logic signed [OUT_W-1:0] k_ff,   k_in;
   logic signed [OUT_W-1:0] b_ff,   b_in;
   logic signed [OUT_W-1:0] sm_ff,  sm_in;
   logic signed [R_W-1:0]   r_ff,   r_in;
   logic        [ACC_W-1:0] acc_ff, acc_in;
   logic                    fit_ff, fit_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   logic                    rv_ff, rv_in;
   logic signed [OUT_W-1:0] o_slope_ff, o_slope_in;
   logic signed [OUT_W-1:0] o_icpt_ff,  o_icpt_in;
   logic signed [OUT_W-1:0] o_sm_ff,    o_sm_in;
   logic        [MAR_W-1:0] o_mar_ff,   o_mar_in;
   logic                    o_fit_ff,   o_fit_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic        [TIME_W-1:0] cur_x;
   logic signed [SMP_W-1:0]  cur_y;
   logic                     incl;
   logic                     accept;
   logic        [NK_W-1:0]   nk_abs;
   logic        [NB_W-1:0]   nb_abs;
   logic signed [NB_W-1:0]   prod_nb;
   logic signed [R_W-1:0]    prod_r;
   logic        [R_W-1:0]    r_abs;
   logic signed [OUT_W-1:0]  quo_sat;
   logic                     quo_neg;
   logic        [MAR_W-1:0]  mar;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign cur_x = time_ff[idx_ff];
   assign cur_y = smp_ff[idx_ff];
   // entry holds real data when it is among the fill_ff newest
   assign incl  = (CNT_W'(idx_ff) + fill_ff) >= CNT_W'(WINDOW);

   assign prod_nb = {{(NB_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign prod_r  = {{(R_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign nk_abs  = nk_ff[NK_W-1] ? NK_W'(-nk_ff) : NK_W'(nk_ff);
   assign nb_abs  = nb_ff[NB_W-1] ? NB_W'(-nb_ff) : NB_W'(nb_ff);
   assign r_abs   = r_ff[R_W-1] ? R_W'(-r_ff) : R_W'(r_ff);

   // divider sign follows the numerator being divided
   assign quo_neg = (state_ff == ST_DIVK) ? nk_ff[NK_W-1] : nb_ff[NB_W-1];

   // saturate quotient magnitude to signed 48 bits
   always_comb begin
      if (quo_neg) begin
         if ((|div_rsp.quotient[DIVN_W-1:OUT_W]) ||
             (div_rsp.quotient[OUT_W-1] && (|div_rsp.quotient[OUT_W-2:0])))
            quo_sat = {1'b1, {(OUT_W-1){1'b0}}};
         else
            quo_sat = -$signed(div_rsp.quotient[OUT_W-1:0]);
      end else begin
         if (|div_rsp.quotient[DIVN_W-1:OUT_W-1])
            quo_sat = {1'b0, {(OUT_W-1){1'b1}}};
         else
            quo_sat = $signed(div_rsp.quotient[OUT_W-1:0]);
      end
   end

   // mean of absolute residuals, clipped to 47 bits
   assign mar = (|acc_ff[ACC_W-1:MAR_W+IDX_W]) ? {MAR_W{1'b1}}
                                                : acc_ff[MAR_W+IDX_W-1:IDX_W];

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_ACC: begin
            mul_a = $signed(MUL_W'(cur_x));
            mul_b = (sub_ff == 4'd0) ? $signed(MUL_W'(cur_x))
                                     : {{(MUL_W-SMP_W){cur_y[SMP_W-1]}}, cur_y};
         end
         ST_PREP: begin
            case (sub_ff[3:1])
               3'd0: begin
                  mul_a = $signed(MUL_W'(t1_ff));
                  mul_b = $signed(MUL_W'(t1_ff));
               end
               3'd1: begin
                  mul_a = $signed(MUL_W'(t1_ff));
                  mul_b = {{(MUL_W-T3_W){t3_ff[T3_W-1]}}, t3_ff};
               end
               3'd2: begin
                  mul_a = $signed(MUL_W'(t0_ff[T0_LO_W-1:0]));
                  mul_b = {{(MUL_W-T3_W){t3_ff[T3_W-1]}}, t3_ff};
               end
               3'd3: begin
                  mul_a = $signed(MUL_W'(t0_ff[T0_W-1:T0_LO_W]));
                  mul_b = {{(MUL_W-T3_W){t3_ff[T3_W-1]}}, t3_ff};
               end
               3'd4: begin
                  mul_a = $signed(MUL_W'(t1_ff));
                  mul_b = $signed(MUL_W'(t2_ff[T2_LO_W-1:0]));
               end
               3'd5: begin
                  mul_a = $signed(MUL_W'(t1_ff));
                  mul_b = {{(MUL_W-T2_W+T2_LO_W){t2_ff[T2_W-1]}},
                           t2_ff[T2_W-1:T2_LO_W]};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_RES: begin
            mul_a = (sub_ff == 4'd0) ? $signed(MUL_W'(k_ff[K_LO_W-1:0]))
                                     : {{(MUL_W-OUT_W+K_LO_W){k_ff[OUT_W-1]}},
                                        k_ff[OUT_W-1:K_LO_W]};
            mul_b = $signed(MUL_W'(cur_x));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer and datapath
   always_comb begin
      state_in = state_ff;
      sub_in   = sub_ff;
      idx_in   = idx_ff;
      fill_in  = fill_ff;
      time_in  = time_ff;
      smp_in   = smp_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      t3_in    = t3_ff;
      den_in   = den_ff;
      nk_in    = nk_ff;
      nb_in    = nb_ff;
      k_in     = k_ff;
      b_in     = b_ff;
      sm_in    = sm_ff;
      r_in     = r_ff;
      acc_in   = acc_ff;
      fit_in   = fit_ff;
      rv_in      = rv_ff && !rsp_chan.ready;
      o_slope_in = o_slope_ff;
      o_icpt_in  = o_icpt_ff;
      o_sm_in    = o_sm_ff;
      o_mar_in   = o_mar_ff;
      o_fit_in   = o_fit_ff;
      div_req.start    = 1'b0;
      div_req.dividend = (state_ff == ST_DIVK)
                         ? {{(DIVN_W-NK_W-FRAC_W){1'b0}}, nk_abs, {FRAC_W{1'b0}}}
                         : {nb_abs, {FRAC_W{1'b0}}};
      div_req.divisor  = den_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // shift, re-base on second-oldest time, append
               for (int i = 0; i < WINDOW - 1; i++) begin
                  time_in[i] = time_ff[i+1] - time_ff[1];
                  smp_in[i]  = smp_ff[i+1];
               end
               time_in[WINDOW-1] = time_ff[WINDOW-1] - time_ff[1]
                                   + TIME_W'(req_chan.delta_time);
               smp_in[WINDOW-1]  = req_chan.sample;
               if (fill_ff != CNT_W'(WINDOW))
                  fill_in = fill_ff + 1'b1;
               t0_in    = '0;
               t1_in    = '0;
               t2_in    = '0;
               t3_in    = '0;
               acc_in   = '0;
               idx_in   = '0;
               sub_in   = '0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (sub_ff == 4'd1) begin
               if (incl)
                  t0_in = t0_ff + prod_ff[T0_W-1:0];
               sub_in = 4'd2;
            end else if (sub_ff == 4'd2) begin
               if (incl) begin
                  t2_in = t2_ff + prod_ff[T2_W-1:0];
                  t1_in = t1_ff + T1_W'(cur_x);
                  t3_in = t3_ff + {{(T3_W-SMP_W){cur_y[SMP_W-1]}}, cur_y};
               end
               sub_in = '0;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == IDX_W'(WINDOW - 1))
                  state_in = ST_PREP;
            end else begin
               sub_in = 4'd1;
            end
         end
         ST_PREP: begin
            // odd steps take the product issued the cycle before
            if (sub_ff[0]) begin
               case (sub_ff[3:1])
                  3'd0: den_in = $signed({1'b0, t0_ff, {IDX_W{1'b0}}})
                                 - prod_ff[DEN_W-1:0];
                  3'd1: nk_in  = $signed({{(NK_W-T2_W-IDX_W){t2_ff[T2_W-1]}},
                                          t2_ff, {IDX_W{1'b0}}})
                                 - prod_ff[NK_W-1:0];
                  3'd2: nb_in  = prod_nb;
                  3'd3: nb_in  = nb_ff + (prod_nb <<< T0_LO_W);
                  3'd4: nb_in  = nb_ff - prod_nb;
                  3'd5: nb_in  = nb_ff - (prod_nb <<< T2_LO_W);
                  default: nb_in = nb_ff;
               endcase
            end
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 4'd11) begin
               sub_in = '0;
               if (den_ff[DEN_W-1] || den_ff == '0) begin
                  fit_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  fit_in   = 1'b1;
                  state_in = ST_DIVK;
               end
            end
         end
         ST_DIVK: begin
            if (sub_ff == 4'd0) begin
               div_req.start = 1'b1;
               sub_in        = 4'd1;
            end else if (div_rsp.done) begin
               k_in     = quo_sat;
               sub_in   = '0;
               state_in = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (sub_ff == 4'd0) begin
               div_req.start = 1'b1;
               sub_in        = 4'd1;
            end else if (div_rsp.done) begin
               b_in     = quo_sat;
               sub_in   = '0;
               idx_in   = '0;
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            sub_in = sub_ff + 1'b1;
            case (sub_ff)
               4'd1: r_in = prod_r + {{(R_W-OUT_W){b_ff[OUT_W-1]}}, b_ff};
               4'd3: r_in = r_ff + (prod_r <<< K_LO_W);
               4'd4: begin
                  // fitted value at the newest time
                  if (idx_ff == IDX_W'(WINDOW - 1)) begin
                     if (r_ff[R_W-1:OUT_W-1] == '0 || r_ff[R_W-1:OUT_W-1] == '1)
                        sm_in = r_ff[OUT_W-1:0];
                     else if (r_ff[R_W-1])
                        sm_in = {1'b1, {(OUT_W-1){1'b0}}};
                     else
                        sm_in = {1'b0, {(OUT_W-1){1'b1}}};
                  end
                  r_in = r_ff - ({{(R_W-SMP_W){cur_y[SMP_W-1]}}, cur_y} <<< FRAC_W);
               end
               4'd5: begin
                  if (incl)
                     acc_in = acc_ff + ACC_W'(r_abs);
                  sub_in = '0;
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff == IDX_W'(WINDOW - 1))
                     state_in = ST_DONE;
               end
               default: r_in = r_ff;
            endcase
         end
         ST_DONE: begin
            // load the output register once it is free
            if (!rv_ff || rsp_chan.ready) begin
               rv_in      = 1'b1;
               o_fit_in   = fit_ff;
               o_slope_in = fit_ff ? k_ff  : '0;
               o_icpt_in  = fit_ff ? b_ff  : '0;
               o_sm_in    = fit_ff ? sm_ff : '0;
               o_mar_in   = fit_ff ? mar   : '0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sub_ff   <= '0;
         idx_ff   <= '0;
         fill_ff  <= '0;
         rv_ff    <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            time_ff[i] <= '0;
            smp_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
         idx_ff   <= idx_in;
         fill_ff  <= fill_in;
         rv_ff    <= rv_in;
         time_ff  <= time_in;
         smp_ff   <= smp_in;
      end
      prod_ff    <= mul_a * mul_b;
      t0_ff      <= t0_in;
      t1_ff      <= t1_in;
      t2_ff      <= t2_in;
      t3_ff      <= t3_in;
      den_ff     <= den_in;
      nk_ff      <= nk_in;
      nb_ff      <= nb_in;
      k_ff       <= k_in;
      b_ff       <= b_in;
      sm_ff      <= sm_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      fit_ff     <= fit_in;
      o_slope_ff <= o_slope_in;
      o_icpt_ff  <= o_icpt_in;
      o_sm_ff    <= o_sm_in;
      o_mar_ff   <= o_mar_in;
      o_fit_ff   <= o_fit_in;
   end

   swlf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_chan.valid             = rv_ff;
   assign rsp_chan.slope             = o_slope_ff;
   assign rsp_chan.intercept         = o_icpt_ff;
   assign rsp_chan.smoothed          = o_sm_ff;
   assign rsp_chan.mean_abs_residual = o_mar_ff;
   assign rsp_chan.fit_valid         = o_fit_ff;

endmodule

/* hw/rtl/swlf_div.sv */
module swlf_div import swlf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [DIVC_W-1:0] cnt_ff,   cnt_in;
   logic [DIVN_W-1:0] quo_ff,   quo_in;
   logic [DEN_W-1:0]  rem_ff,   rem_in;
   logic [DEN_W-1:0]  dsr_ff,   dsr_in;

   logic [DEN_W:0]    rem_sh;
   logic [DEN_W:0]    diff;

   // one restoring step: shift in next dividend bit, try subtract
   assign rem_sh = {rem_ff, quo_ff[DIVN_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[DIVN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIVC_W'(DIVN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   import swlf_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] slope;
      logic signed [OUT_W-1:0] intercept;
      logic signed [OUT_W-1:0] smoothed;
      logic        [MAR_W-1:0] mean_abs_residual;
      logic                    fit_valid;
   } line_fit_type;

   typedef struct {
      logic        [DT_W-1:0]  dt;
      logic signed [SMP_W-1:0] smp;
      bit                      zero_fit;  // expected result is the cleared fit
   } step_row_type;

   localparam int WATCHDOG_LIMIT = 12000;
   localparam int HOLD_CYCLES    = 2500;
   localparam int RANDOM_ITEMS   = 1830;

   logic clock;
   logic reset;

   swlf_req_if req_bus ();
   swlf_rsp_if rsp_bus ();

   sliding_window_line_fit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // window model
   logic        [TIME_W-1:0] time_win [WINDOW];
   logic signed [SMP_W-1:0]  smp_win  [WINDOW];
   int                       fill_cnt;

   line_fit_type fit_q [$];
   int           errors;
   int           idle_cycles;
   bit           cur_zero_fit;
   bit           hold_rsp;

   step_row_type dir_rows [] = '{
      '{16'd0,     16'sd0,      1'b1},
      '{16'd0,     16'sd32767,  1'b1},
      '{16'd0,     -16'sd32768, 1'b1},
      '{16'd65535, 16'sd32767,  1'b0},
      '{16'd65535, -16'sd32768, 1'b0},
      '{16'd1,     -16'sd32768, 1'b0},
      '{16'd1,     16'sd32767,  1'b0},
      '{16'd0,     16'sd0,      1'b0},
      '{16'd65535, -16'sd1,     1'b0},
      '{16'd1,     16'sd1,      1'b0},
      '{16'd32768, 16'sd16384,  1'b0},
      '{16'd2,     -16'sd32768, 1'b0},
      '{16'd65535, 16'sd32767,  1'b0},
      '{16'd65535, 16'sd32767,  1'b0},
      '{16'd1,     -16'sd32768, 1'b0},
      '{16'd3,     16'sd12345,  1'b0},
      '{16'd65535, -16'sd32768, 1'b0},
      '{16'd1,     16'sd32767,  1'b0},
      '{16'd0,     -16'sd2,     1'b0},
      '{16'd21845, 16'sd21845,  1'b0}
   };

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic wide_type sat_wide(input wide_type a, input wide_type lo,
                                         input wide_type hi);
      if (a < lo) return lo;
      if (a > hi) return hi;
      return a;
   endfunction

   // shift the window, append the new pair and fit the line
   function automatic line_fit_type fit_next(input logic [DT_W-1:0] dt,
                                             input logic signed [SMP_W-1:0] y);
      logic        [TIME_W-1:0] base;
      logic        [63:0]       s_xx, s_x;
      logic signed [63:0]       s_xy, s_y, den;
      wide_type                 nk, nb, k, b, r, acc, x, lo48, hi48;
      int                       first;
      line_fit_type             f;
      base = time_win[1];
      for (int i = 0; i < WINDOW - 1; i++) begin
         time_win[i] = time_win[i+1] - base;
         smp_win[i]  = smp_win[i+1];
      end
      time_win[WINDOW-1] = time_win[WINDOW-2] + TIME_W'(dt);
      smp_win[WINDOW-1]  = y;
      if (fill_cnt < WINDOW) fill_cnt++;
      f = '0;
      s_xx = 0; s_x = 0; s_xy = 0; s_y = 0;
      first = WINDOW - fill_cnt;
      for (int i = first; i < WINDOW; i++) begin
         s_xx += 64'(time_win[i]) * 64'(time_win[i]);
         s_x  += 64'(time_win[i]);
         s_xy += 64'(signed'({1'b0, time_win[i]})) * 64'(smp_win[i]);
         s_y  += 64'(smp_win[i]);
      end
      den = $signed(s_xx * WINDOW) - $signed(s_x * s_x);
      if (den <= 0) return f;
      lo48 = -(wide_type'(1) <<< 47);
      hi48 = (wide_type'(1) <<< 47) - 1;
      nk = wide_type'(s_xy) * WINDOW - wide_type'($signed(s_x)) * wide_type'(s_y);
      nb = wide_type'($signed(s_xx)) * wide_type'(s_y)
           - wide_type'($signed(s_x)) * wide_type'(s_xy);
      k = sat_wide((nk <<< FRAC_W) / wide_type'(den), lo48, hi48);
      b = sat_wide((nb <<< FRAC_W) / wide_type'(den), lo48, hi48);
      acc = 0;
      for (int i = first; i < WINDOW; i++) begin
         x = wide_type'(signed'({1'b0, time_win[i]}));
         r = k * x + b - wide_type'(smp_win[i]) * 65536;
         acc += (r < 0) ? -r : r;
      end
      x = wide_type'(signed'({1'b0, time_win[WINDOW-1]}));
      f.slope             = k[OUT_W-1:0];
      f.intercept         = b[OUT_W-1:0];
      f.smoothed          = OUT_W'(sat_wide(k * x + b, lo48, hi48));
      f.mean_abs_residual = MAR_W'(sat_wide(acc / WINDOW, '0, hi48));
      f.fit_valid         = 1'b1;
      return f;
   endfunction

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] exp);
      $display("mismatch %s: got %h expected %h at %0t", field, got, exp, $realtime);
      errors++;
   endtask

   // random gap: mostly none or short, a few long
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 400);
   endfunction

   // offer one item and wait for it to be taken; returns at a falling edge
   task automatic send_item(input logic [DT_W-1:0] dt, input logic signed [SMP_W-1:0] smp,
                            input bit zero_fit, input bit no_gap);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.delta_time <= dt;
      req_bus.sample     <= smp;
      cur_zero_fit       <= zero_fit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [DT_W-1:0] rand_dt();
      int p;
      p = $urandom_range(99);
      if (p < 10) return '0;
      if (p < 40) return DT_W'($urandom_range(1, 15));
      if (p < 65) return DT_W'($urandom_range(1, 300));
      return DT_W'($urandom_range(0, 65535));
   endfunction

   // stimulus
   initial begin
      int sent;
      int burst;
      bit stalled;
      bit drained;
      req_bus.valid      = 1'b0;
      req_bus.delta_time = '0;
      req_bus.sample     = '0;
      rsp_bus.ready      = 1'b0;
      cur_zero_fit       = 1'b0;
      hold_rsp           = 1'b0;
      stalled            = 1'b0;
      drained            = 1'b0;
      reset              = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].dt, dir_rows[i].smp, dir_rows[i].zero_fit, 1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (!stalled && sent >= 700) begin
            // long receiver stall with the sender pushing back to back
            stalled  = 1'b1;
            hold_rsp = 1'b1;
            repeat (12) send_item(rand_dt(), SMP_W'($urandom), 1'b0, 1'b1);
            sent += 12;
         end else if (!drained && sent >= 1200) begin
            // drain everything before going on
            drained = 1'b1;
            req_bus.valid <= 1'b0;
            while (fit_q.size() != 0) @(negedge clock);
            @(negedge clock);
         end
         if ($urandom_range(99) < 3) begin
            // run of equal times drives the denominator to zero
            burst = $urandom_range(16, 20);
            repeat (burst) send_item('0, SMP_W'($urandom), 1'b0, 1'b0);
            sent += burst;
         end else begin
            send_item(rand_dt(), SMP_W'($urandom), 1'b0, 1'b0);
            sent++;
         end
      end
      req_bus.valid <= 1'b0;

      while (fit_q.size() != 0) @(negedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // result side ready
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if ($urandom_range(99) < 3) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(50, 600)) @(negedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(99) < 15) ? 1'b0 : 1'b1;
            @(negedge clock);
         end
      end
   end

   // predict on accepted inputs, check accepted results
   always @(posedge clock) begin
      line_fit_type exp;
      line_fit_type got;
      if (reset) begin
         foreach (time_win[i]) begin
            time_win[i] = '0;
            smp_win[i]  = '0;
         end
         fill_cnt    = 0;
         idle_cycles = 0;
         errors      = 0;
      end else begin
         idle_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            idle_cycles = 0;
            exp = fit_next(req_bus.delta_time, req_bus.sample);
            if (cur_zero_fit) exp = '0;
            fit_q.push_back(exp);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            idle_cycles = 0;
            got.slope             = rsp_bus.slope;
            got.intercept         = rsp_bus.intercept;
            got.smoothed          = rsp_bus.smoothed;
            got.mean_abs_residual = rsp_bus.mean_abs_residual;
            got.fit_valid         = rsp_bus.fit_valid;
            if (fit_q.size() == 0) begin
               report("unexpected item", 64'(got.slope), '0);
            end else begin
               exp = fit_q.pop_front();
               if (got.slope !== exp.slope)
                  report("slope", 64'(got.slope), 64'(exp.slope));
               if (got.intercept !== exp.intercept)
                  report("intercept", 64'(got.intercept), 64'(exp.intercept));
               if (got.smoothed !== exp.smoothed)
                  report("smoothed", 64'(got.smoothed), 64'(exp.smoothed));
               if (got.mean_abs_residual !== exp.mean_abs_residual)
                  report("mean_abs_residual", 64'(got.mean_abs_residual),
                         64'(exp.mean_abs_residual));
               if (got.fit_valid !== exp.fit_valid)
                  report("fit_valid", 64'(got.fit_valid), 64'(exp.fit_valid));
            end
         end
         // watchdog
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule
